// ===== rtl/core/rbd_pkg.sv =====
// Shared types and constants for the ring buffer deque.
package rbd_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int WIDTH_DEF = 32;

   localparam int ACTION_W = 3;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_BACK  = 3'd0,
      ACT_PUSH_FRONT = 3'd1,
      ACT_POP_BACK   = 3'd2,
      ACT_POP_FRONT  = 3'd3,
      ACT_PEEK_FRONT = 3'd4,
      ACT_PEEK_BACK  = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      CS_IDLE,
      CS_LOAD
   } ctrl_state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic exec;  // perform the accepted request on the store and indices
      logic load;  // move the pending result into the output register
   } rbd_cmd_type;

endpackage

// ===== rtl/core/rbd_ctrl.sv =====
// Controller: request handshake, sequencing and output register valid.
module rbd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rbd_pkg::rbd_cmd_type cmd
);
   import rbd_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         CS_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.exec = 1'b1;
               state_in = CS_LOAD;
            end
         end
         CS_LOAD: begin
            // wait here until the output register can take the result
            if (out_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> out_free)
      else $error("result loaded over an unread response");
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> !cmd.exec)
      else $error("request accepted while another is in flight");
   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid_ff)
      else $error("loaded result not presented");
`endif

endmodule

// ===== rtl/core/rbd_datapath.sv =====
// Datapath: slot store, head/tail indices, element count and result registers.
module rbd_datapath #(
   parameter int DEPTH = rbd_pkg::DEPTH_DEF,
   parameter int WIDTH = rbd_pkg::WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rbd_pkg::rbd_cmd_type          cmd,
   input  logic [rbd_pkg::ACTION_W-1:0]  req_action,
   input  logic [rbd_pkg::DATA_W-1:0]    req_data_in,
   output logic [rbd_pkg::DATA_W-1:0]    rsp_data_out,
   output logic [rbd_pkg::STATUS_W-1:0]  rsp_status,
   output logic [rbd_pkg::OCC_W-1:0]     rsp_occupancy
);
   import rbd_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];

   logic [IDX_W-1:0] head_gap_ff, head_gap_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [WIDTH-1:0]    rd_data_ff;
   logic                rd_ok_ff;
   status_type          pend_status_ff;
   logic [OCC_W-1:0]    pend_occ_ff;
   logic [DATA_W-1:0]   data_out_ff;
   status_type          status_ff;
   logic [OCC_W-1:0]    occ_ff;

   logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic             wr_en, rd_en;
   logic             is_push, is_read, full, empty;
   status_type       status_c;

   assign head_inc = (head_gap_ff == IDX_W'(DEPTH - 1)) ? '0 : head_gap_ff + IDX_W'(1);
   assign head_dec = (head_gap_ff == '0) ? IDX_W'(DEPTH - 1) : head_gap_ff - IDX_W'(1);
   assign tail_inc = (tail_ff == IDX_W'(DEPTH - 1)) ? '0 : tail_ff + IDX_W'(1);
   assign tail_dec = (tail_ff == '0) ? IDX_W'(DEPTH - 1) : tail_ff - IDX_W'(1);

   assign is_push = (req_action == ACT_PUSH_BACK) || (req_action == ACT_PUSH_FRONT);
   assign is_read = (req_action == ACT_POP_BACK) || (req_action == ACT_POP_FRONT) ||
                    (req_action == ACT_PEEK_FRONT) || (req_action == ACT_PEEK_BACK);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);

   always_comb begin
      status_c    = ST_OK;
      head_gap_in = head_gap_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      wr_addr     = tail_inc;
      rd_addr     = tail_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      priority if (is_push && full) begin
         status_c = ST_FULL;
      end else if (is_read && empty) begin
         status_c = ST_EMPTY;
      end else begin
         unique case (req_action)
            ACT_PUSH_BACK: begin
               wr_addr  = tail_inc;
               wr_en    = 1'b1;
               tail_in  = tail_inc;
               count_in = count_ff + CNT_W'(1);
            end
            ACT_PUSH_FRONT: begin
               wr_addr     = head_gap_ff;
               wr_en       = 1'b1;
               head_gap_in = head_dec;
               count_in    = count_ff + CNT_W'(1);
            end
            ACT_POP_BACK: begin
               rd_addr  = tail_ff;
               rd_en    = 1'b1;
               tail_in  = tail_dec;
               count_in = count_ff - CNT_W'(1);
            end
            ACT_POP_FRONT: begin
               rd_addr     = head_inc;
               rd_en       = 1'b1;
               head_gap_in = head_inc;
               count_in    = count_ff - CNT_W'(1);
            end
            ACT_PEEK_FRONT: begin
               rd_addr = head_inc;
               rd_en   = 1'b1;
            end
            ACT_PEEK_BACK: begin
               rd_addr = tail_ff;
               rd_en   = 1'b1;
            end
            default: begin
               // unused codes: no change, zero data, status ok
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_gap_ff <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
      end else if (cmd.exec) begin
         head_gap_ff <= head_gap_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem[wr_addr] <= WIDTH'(req_data_in);
      end
      if (cmd.exec && rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rd_ok_ff       <= rd_en;
         pend_status_ff <= status_c;
         pend_occ_ff    <= OCC_W'(count_in);
      end
      if (cmd.load) begin
         data_out_ff <= rd_ok_ff ? DATA_W'(rd_data_ff) : '0;
         status_ff   <= pend_status_ff;
         occ_ff      <= pend_occ_ff;
      end
   end

   assign rsp_data_out  = data_out_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = occ_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count above capacity");
   a_index_ring: assert property (@(posedge clock) disable iff (reset)
      ((CNT_W + 1)'(head_gap_ff) + (CNT_W + 1)'(count_ff) == (CNT_W + 1)'(tail_ff)) ||
      ((CNT_W + 1)'(head_gap_ff) + (CNT_W + 1)'(count_ff) ==
       (CNT_W + 1)'(tail_ff) + (CNT_W + 1)'(DEPTH)))
      else $error("head, tail and count out of step");
   a_error_keeps_state: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && (status_c != ST_OK) |=>
      (count_ff == $past(count_ff)) && (tail_ff == $past(tail_ff)) &&
      (head_gap_ff == $past(head_gap_ff)))
      else $error("failed request changed the deque");
`endif

endmodule

// ===== rtl/core/ring_buffer_deque_unit.sv =====
// Top level of the ring buffer deque: controller plus datapath.
//
// Fixed-capacity double-ended queue of DEPTH entries of WIDTH bits.
// Request channel (req_valid/req_stall): req_action selects push back,
// push front, pop back, pop front, peek front or peek back; req_data_in
// is the element for a push. Response channel (rsp_valid/rsp_stall):
// one response per request with rsp_data_out, rsp_status (ok, full,
// empty) and rsp_occupancy after the action.
// A request accepted at one edge is performed on the store at that edge,
// where the store read, status and occupancy are registered as pending;
// they move to the output register once it is free. The controller keeps
// one request in flight and takes no new one until its response is loaded.
// The output register holds the response while rsp_stall is high, and
// req_stall stays high until the pending response has been loaded.
// Reset empties the deque (head, tail and count to zero) and drops any
// pending response; store contents are not cleared.
module ring_buffer_deque_unit #(
   parameter int DEPTH = rbd_pkg::DEPTH_DEF,
   parameter int WIDTH = rbd_pkg::WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rbd_pkg::ACTION_W-1:0]  req_action,
   input  logic [rbd_pkg::DATA_W-1:0]    req_data_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rbd_pkg::DATA_W-1:0]    rsp_data_out,
   output logic [rbd_pkg::STATUS_W-1:0]  rsp_status,
   output logic [rbd_pkg::OCC_W-1:0]     rsp_occupancy
);
   import rbd_pkg::*;

   rbd_cmd_type cmd;

   rbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   rbd_datapath #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_action    (req_action),
      .req_data_in   (req_data_in),
      .rsp_data_out  (rsp_data_out),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule

// ===== test/ring_buffer_deque_monitor.sv =====
// Monitor for the ring buffer deque: mirrors the deque and checks every response in order.
module ring_buffer_deque_monitor
   import rbd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [DATA_W-1:0]   req_data_in,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [DATA_W-1:0]   rsp_data_out,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [OCC_W-1:0]    rsp_occupancy,
   output int                  mismatch_count,
   output int                  pending_count
);

   localparam int DEPTH = DEPTH_DEF;
   localparam int IDX_W = $clog2(DEPTH);

   typedef struct packed {
      logic [DATA_W-1:0] data;
      status_type        status;
      logic [OCC_W-1:0]  occupancy;
   } deque_reply_type;

   logic [WIDTH_DEF-1:0] slots [DEPTH];
   logic [IDX_W-1:0]     head_gap = '0;
   logic [IDX_W-1:0]     tail = '0;
   logic [OCC_W-1:0]     count = '0;
   deque_reply_type      replies_due [$];
   int                   errors = 0;

   // Applies one request to the mirrored deque; indices wrap at the store depth.
   function automatic deque_reply_type perform_action(input logic [ACTION_W-1:0] act,
                                                      input logic [DATA_W-1:0] val);
      deque_reply_type r;
      logic            is_push;
      logic            is_read;
      r = '{data: '0, status: ST_OK, occupancy: '0};
      is_push = act inside {ACT_PUSH_BACK, ACT_PUSH_FRONT};
      is_read = act inside {ACT_POP_BACK, ACT_POP_FRONT, ACT_PEEK_FRONT, ACT_PEEK_BACK};
      if (is_push && count == DEPTH) begin
         r.status = ST_FULL;
      end else if (is_read && count == 0) begin
         r.status = ST_EMPTY;
      end else begin
         case (act)
            ACT_PUSH_BACK: begin
               tail = tail + 1'b1;
               slots[tail] = val;
               count = count + 1'b1;
            end
            ACT_PUSH_FRONT: begin
               slots[head_gap] = val;
               head_gap = head_gap - 1'b1;
               count = count + 1'b1;
            end
            ACT_POP_BACK: begin
               r.data = slots[tail];
               tail = tail - 1'b1;
               count = count - 1'b1;
            end
            ACT_POP_FRONT: begin
               head_gap = head_gap + 1'b1;
               r.data = slots[head_gap];
               count = count - 1'b1;
            end
            ACT_PEEK_FRONT: r.data = slots[IDX_W'(head_gap + 1'b1)];
            ACT_PEEK_BACK:  r.data = slots[tail];
            default: ;  // unused codes leave the deque alone
         endcase
      end
      r.occupancy = count;
      return r;
   endfunction

   task automatic flag_field(input string field, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
      errors++;
      if (errors <= 10)
         $display("mismatch on %s: expected %h, got %h", field, want, got);
   endtask

   always @(posedge clock) begin : score_step
      deque_reply_type want;
      if (reset) begin
         head_gap = '0;
         tail = '0;
         count = '0;
         replies_due.delete();
      end else begin
         if (req_valid && !req_stall)
            replies_due.push_back(perform_action(req_action, req_data_in));
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               flag_field("response with no request", DATA_W'(0), rsp_data_out);
            end else begin
               want = replies_due.pop_front();
               if (rsp_data_out !== want.data)
                  flag_field("data_out", want.data, rsp_data_out);
               if (rsp_status !== want.status)
                  flag_field("status", DATA_W'(want.status), DATA_W'(rsp_status));
               if (rsp_occupancy !== want.occupancy)
                  flag_field("occupancy", DATA_W'(want.occupancy), DATA_W'(rsp_occupancy));
            end
         end
      end
      mismatch_count <= errors;
      pending_count <= replies_due.size();
   end

endmodule

// ===== test/ring_buffer_deque_unit_test.sv =====
// Testbench top for the ring buffer deque: drives requests and gives the verdict.
module ring_buffer_deque_unit_test;
   import rbd_pkg::*;

   // Codes outside the action set; the block must ignore them.
   localparam logic [ACTION_W-1:0] ACT_UNUSED_6 = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_7 = 3'd7;
   localparam int QUIET_LIMIT      = 2000;
   localparam int SETTLE_CYCLES    = 8;
   localparam int RANDOM_PER_PHASE = 275;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ACTION_W-1:0] req_action = '0;
   logic [DATA_W-1:0]   req_data_in = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [DATA_W-1:0]   rsp_data_out;
   logic [STATUS_W-1:0] rsp_status;
   logic [OCC_W-1:0]    rsp_occupancy;
   int                  mismatch_count;
   int                  pending_count;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   int                  quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ring_buffer_deque_unit u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_data_in   (req_data_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data_out  (rsp_data_out),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

   ring_buffer_deque_monitor u_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_data_in    (req_data_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data_out   (rsp_data_out),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Watchdog: ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_data_in <= val;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   function automatic logic [ACTION_W-1:0] pick_action(input int push_pct);
      if ($urandom_range(99) < 3)
         return $urandom_range(1) ? ACT_UNUSED_7 : ACT_UNUSED_6;
      if ($urandom_range(99) < push_pct)
         return $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
      case ($urandom_range(7))
         0, 1, 2: return ACT_POP_BACK;
         3, 4, 5: return ACT_POP_FRONT;
         6:       return ACT_PEEK_FRONT;
         default: return ACT_PEEK_BACK;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_data();
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // Bursts lean toward filling, draining or a mix so the deque swings between full and empty.
   task automatic run_phase(input int send_pct, input int recv_pct, input int n_items);
      int sent;
      int burst_len;
      int push_pct;
      bit paused;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      paused = 1'b0;
      while (sent < n_items) begin
         burst_len = $urandom_range(40, 6);
         case ($urandom_range(2))
            0:       push_pct = 85;
            1:       push_pct = 15;
            default: push_pct = 50;
         endcase
         repeat (burst_len) send_request(pick_action(push_pct), pick_data());
         sent += burst_len;
         if (!paused && sent > n_items / 2) begin
            wait_for_drain();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty deque: every read reports empty, unused codes do nothing; then fill to full and pop both ends
      send_request(ACT_PEEK_FRONT, '0);
      send_request(ACT_PEEK_BACK, '1);
      send_request(ACT_POP_BACK, '0);
      send_request(ACT_POP_FRONT, '1);
      send_request(ACT_UNUSED_6, '1);
      send_request(ACT_UNUSED_7, '0);
      send_request(ACT_PUSH_BACK, '0);
      send_request(ACT_PUSH_FRONT, '1);
      send_request(ACT_PEEK_FRONT, '0);
      send_request(ACT_PEEK_BACK, '0);
      for (int i = 0; i < 14; i++)
         send_request(i[0] ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
                      i[0] ? 32'hAAAA_AAAA ^ i : 32'h5555_5555 ^ i);
      send_request(ACT_PUSH_BACK, 32'hDEAD_BEEF);  // full
      send_request(ACT_POP_BACK, '0);
      send_request(ACT_POP_FRONT, '0);

      run_phase(31, 52, RANDOM_PER_PHASE);
      run_phase(52, 31, RANDOM_PER_PHASE);
      run_phase(0, 0, RANDOM_PER_PHASE);

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
